FILE: src/isb_pkg.sv
// shared types, register map and constants for the indexed sprite pixel blitter
// no dependencies; imported by every module of the block
package isb_pkg;

  // template index codes
  localparam int unsigned MAX_SPRITE_SIDE   = 64;
  localparam logic [7:0]  EYES_INDEX        = 8'd6;
  localparam logic [7:0]  TRANSPARENT_INDEX = 8'd0;
  localparam logic [7:0]  FIRST_PAL_INDEX   = 8'd1;
  localparam logic [7:0]  LAST_PAL_INDEX    = 8'd5;
  localparam int unsigned PAL_COUNT         = 5;

  localparam logic [15:0] WHITE_565  = 16'hFFFF;
  localparam logic [8:0]  FULL_LEVEL = 9'd256;
  localparam logic [10:0] COORD_LIMIT = 11'd1024;

  // register indexes, byte address is 4 * index
  localparam int unsigned ADDR_W = 5;
  localparam logic [2:0] REG_PALETTE_ONE   = 3'd0;
  localparam logic [2:0] REG_PALETTE_TWO   = 3'd1;
  localparam logic [2:0] REG_PALETTE_THREE = 3'd2;
  localparam logic [2:0] REG_PALETTE_FOUR  = 3'd3;
  localparam logic [2:0] REG_PALETTE_FIVE  = 3'd4;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd5;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd6;
  localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd7;

  localparam logic [10:0] SCREEN_WIDTH_RST  = 11'd320;
  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd240;
  localparam logic [6:0]  SPRITE_WIDTH_RST  = 7'd16;

  typedef logic [PAL_COUNT-1:0][15:0] palette_t;

  typedef struct packed {
    palette_t    palette;
    logic [10:0] screen_width;
    logic [10:0] screen_height;
    logic [6:0]  sprite_width;
  } cfg_t;

  // after decode: colour chosen, column mirrored, level clamped
  typedef struct packed {
    logic [15:0]        color;
    logic [6:0]         dcol;
    logic [6:0]         reveal;
    logic [5:0]         srow;
    logic signed [10:0] origin_x;
    logic signed [10:0] origin_y;
    logic [8:0]         level;
  } dec_t;

  // after products and coordinate sums
  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         green_add;
    logic [7:0]         blue;
    logic signed [11:0] dx;
    logic signed [11:0] dy;
  } mix_t;

endpackage

FILE: src/indexed_sprite_pixel_blit_top.sv
// top level of the indexed sprite pixel blitter
// depends on isb_pkg, isb_regs, isb_decode, isb_mix and isb_emit
//
//   channel   handshake                  payload
//   texel     texel_valid / texel_stall  pixel_index .. green_level, one template pixel
//   pixel     pixel_valid / pixel_stall  pixel_x, pixel_y, pixel_color
//   config    apb: psel penable pwrite   paddr, pwdata, prdata
//
// three register stages: decode, tint products and coordinate sums, blend and clip
// texel requests pass the decode, mix and emit registers; one request per cycle unless
// pixel_stall holds the pipe; the rate is set by the stage chain, each stage holds one request
// dropped texels become bubbles at the stage that rejects them and never show
// pixel_stall backs up stage by stage; a stage with a bubble still takes a request
// synchronous reset clears all valid bits and loads the register defaults
module indexed_sprite_pixel_blit_top (
  input  logic                       clk,
  input  logic                       rst,
  // texel request
  input  logic                       texel_valid,
  output logic                       texel_stall,
  input  logic [7:0]                 pixel_index,
  input  logic [5:0]                 source_column,
  input  logic [5:0]                 source_row,
  input  logic signed [10:0]         origin_x,
  input  logic signed [10:0]         origin_y,
  input  logic                       mirror,
  input  logic [6:0]                 reveal_columns,
  input  logic [8:0]                 green_level,
  // pixel request
  output logic                       pixel_valid,
  input  logic                       pixel_stall,
  output logic [9:0]                 pixel_x,
  output logic [9:0]                 pixel_y,
  output logic [15:0]                pixel_color,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [isb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import isb_pkg::*;

  cfg_t cfg;
  dec_t dec_data;
  mix_t mix_data;
  logic dec_valid;
  logic dec_ready;
  logic mix_valid;
  logic mix_ready;
  logic emit_ready;

  // palette, screen geometry; user, not block, keeps stable while requests are in flight
  isb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage one: colour select and template bounds
  isb_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .up_valid       (texel_valid),
    .pixel_index    (pixel_index),
    .source_column  (source_column),
    .source_row     (source_row),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .mirror         (mirror),
    .reveal_columns (reveal_columns),
    .green_level    (green_level),
    .up_ready       (dec_ready),
    .down_ready     (mix_ready),
    .valid          (dec_valid),
    .data           (dec_data)
  );

  // stage two: reveal limit, tint multiplies, screen position
  isb_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (dec_valid),
    .up_data    (dec_data),
    .up_ready   (mix_ready),
    .down_ready (emit_ready),
    .valid      (mix_valid),
    .data       (mix_data)
  );

  // stage three: green blend, repack, clip; its register is the output
  isb_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .up_valid    (mix_valid),
    .up_data     (mix_data),
    .up_ready    (emit_ready),
    .down_stall  (pixel_stall),
    .valid       (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color)
  );

  // stall only when every stage is full and the sink holds the result
  assign texel_stall = !dec_ready;

endmodule

FILE: src/isb_regs.sv
// configuration register file with an apb-style slave port
// depends on isb_pkg for the register map and cfg_t
module isb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [isb_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output isb_pkg::cfg_t              cfg
);
  import isb_pkg::*;

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[ADDR_W-1:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.palette       <= '0;
      cfg.screen_width  <= SCREEN_WIDTH_RST;
      cfg.screen_height <= SCREEN_HEIGHT_RST;
      cfg.sprite_width  <= SPRITE_WIDTH_RST;
    end else if (wr_en) begin
      case (reg_index)
        REG_PALETTE_ONE:   cfg.palette[0]    <= pwdata[15:0];
        REG_PALETTE_TWO:   cfg.palette[1]    <= pwdata[15:0];
        REG_PALETTE_THREE: cfg.palette[2]    <= pwdata[15:0];
        REG_PALETTE_FOUR:  cfg.palette[3]    <= pwdata[15:0];
        REG_PALETTE_FIVE:  cfg.palette[4]    <= pwdata[15:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= pwdata[10:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[10:0];
        REG_SPRITE_WIDTH:  cfg.sprite_width  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PALETTE_ONE:   prdata = {16'd0, cfg.palette[0]};
      REG_PALETTE_TWO:   prdata = {16'd0, cfg.palette[1]};
      REG_PALETTE_THREE: prdata = {16'd0, cfg.palette[2]};
      REG_PALETTE_FOUR:  prdata = {16'd0, cfg.palette[3]};
      REG_PALETTE_FIVE:  prdata = {16'd0, cfg.palette[4]};
      REG_SCREEN_WIDTH:  prdata = {21'd0, cfg.screen_width};
      REG_SCREEN_HEIGHT: prdata = {21'd0, cfg.screen_height};
      REG_SPRITE_WIDTH:  prdata = {25'd0, cfg.sprite_width};
      default:           prdata = '0;
    endcase
  end

endmodule

FILE: src/isb_decode.sv
// pipeline stage one: palette lookup, template bounds, column mirror, level clamp
// depends on isb_pkg for cfg_t, dec_t and the index codes
module isb_decode (
  input  logic                clk,
  input  logic                rst,
  input  isb_pkg::cfg_t       cfg,
  input  logic                up_valid,
  input  logic [7:0]          pixel_index,
  input  logic [5:0]          source_column,
  input  logic [5:0]          source_row,
  input  logic signed [10:0]  origin_x,
  input  logic signed [10:0]  origin_y,
  input  logic                mirror,
  input  logic [6:0]          reveal_columns,
  input  logic [8:0]          green_level,
  output logic                up_ready,
  input  logic                down_ready,
  output logic                valid,
  output isb_pkg::dec_t       data
);
  import isb_pkg::*;

  logic       is_pal;
  logic       is_eye;
  logic       col_ok;
  logic       row_ok;
  logic       keep;
  logic [6:0] scol_w;
  logic [2:0] pal_sel;
  dec_t       data_next;

  assign is_eye  = (pixel_index == EYES_INDEX) && (pixel_index != TRANSPARENT_INDEX);
  assign is_pal  = pixel_index inside {[FIRST_PAL_INDEX:LAST_PAL_INDEX]};
  assign pal_sel = 3'(pixel_index - FIRST_PAL_INDEX);
  assign scol_w  = {1'b0, source_column};
  assign col_ok  = (scol_w < cfg.sprite_width) && (32'(source_column) < MAX_SPRITE_SIDE);
  assign row_ok  = 32'(source_row) < MAX_SPRITE_SIDE;
  assign keep    = (is_eye || is_pal) && col_ok && row_ok;

  always_comb begin
    data_next.color    = is_eye ? WHITE_565 : cfg.palette[pal_sel];
    data_next.dcol     = mirror ? 7'(cfg.sprite_width - 7'd1 - scol_w) : scol_w;
    data_next.reveal   = reveal_columns;
    data_next.srow     = source_row;
    data_next.origin_x = origin_x;
    data_next.origin_y = origin_y;
    data_next.level    = (green_level > FULL_LEVEL) ? FULL_LEVEL : green_level;
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

endmodule

FILE: src/isb_mix.sv
// pipeline stage two: reveal limit, tint products, screen coordinate sums
// depends on isb_pkg for dec_t and mix_t
module isb_mix (
  input  logic          clk,
  input  logic          rst,
  input  logic          up_valid,
  input  isb_pkg::dec_t up_data,
  output logic          up_ready,
  input  logic          down_ready,
  output logic          valid,
  output isb_pkg::mix_t data
);
  import isb_pkg::*;

  logic [7:0]  r8;
  logic [7:0]  g8;
  logic [7:0]  b8;
  logic [8:0]  inv_level;
  logic [16:0] r_prod;
  logic [16:0] b_prod;
  logic [16:0] g_prod;
  logic        reveal_ok;
  mix_t        data_next;

  assign r8        = {up_data.color[15:11], 3'b000};
  assign g8        = {up_data.color[10:5], 2'b00};
  assign b8        = {up_data.color[4:0], 3'b000};
  assign inv_level = FULL_LEVEL - up_data.level;

  // 8 x 9 products, q1.8 scale
  assign r_prod = 17'(r8) * 17'(inv_level);
  assign b_prod = 17'(b8) * 17'(inv_level);
  assign g_prod = 17'(8'd255 - g8) * 17'(up_data.level);

  assign reveal_ok = up_data.dcol < up_data.reveal;

  always_comb begin
    data_next.red       = r_prod[15:8];
    data_next.blue      = b_prod[15:8];
    data_next.green     = g8;
    data_next.green_add = g_prod[16:9];
    data_next.dx        = 12'(up_data.origin_x) + $signed({5'd0, up_data.dcol});
    data_next.dy        = 12'(up_data.origin_y) + $signed({6'd0, up_data.srow});
  end

  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid && reveal_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

endmodule

FILE: src/isb_emit.sv
// pipeline stage three: green blend, rgb565 repack, screen clip, result register
// depends on isb_pkg for cfg_t, mix_t and COORD_LIMIT
module isb_emit (
  input  logic          clk,
  input  logic          rst,
  input  isb_pkg::cfg_t cfg,
  input  logic          up_valid,
  input  isb_pkg::mix_t up_data,
  output logic          up_ready,
  input  logic          down_stall,
  output logic          valid,
  output logic [9:0]    pixel_x,
  output logic [9:0]    pixel_y,
  output logic [15:0]   pixel_color
);
  import isb_pkg::*;

  logic [10:0] sw_lim;
  logic [10:0] sh_lim;
  logic [7:0]  g_new;
  logic        on_screen;

  assign sw_lim = (cfg.screen_width  > COORD_LIMIT) ? COORD_LIMIT : cfg.screen_width;
  assign sh_lim = (cfg.screen_height > COORD_LIMIT) ? COORD_LIMIT : cfg.screen_height;
  assign g_new  = up_data.green + up_data.green_add;

  // sign bit clear, then magnitude below the clamped screen size
  assign on_screen = !up_data.dx[11] && (up_data.dx[10:0] < sw_lim) &&
                     !up_data.dy[11] && (up_data.dy[10:0] < sh_lim);

  assign up_ready = !valid || !down_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid && on_screen;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      pixel_x     <= up_data.dx[9:0];
      pixel_y     <= up_data.dy[9:0];
      pixel_color <= {up_data.red[7:3], g_new[7:2], up_data.blue[7:3]};
    end
  end

endmodule

FILE: src/isb_checker.sv
// port-level checks for the indexed sprite pixel blitter, bound to the top level
// depends on isb_pkg for the address width
module isb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       texel_valid,
  input logic                       texel_stall,
  input logic                       pixel_valid,
  input logic                       pixel_stall,
  input logic [9:0]                 pixel_x,
  input logic [9:0]                 pixel_y,
  input logic [15:0]                pixel_color,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [isb_pkg::ADDR_W-1:0] paddr
);
  import isb_pkg::*;

  // a stalled pixel request stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid)
    else $error("pixel request dropped while stalled");

  // and keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=>
      $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color))
    else $error("pixel payload changed while stalled");

  // an empty output register means the whole pipe can advance
  a_no_false_stall: assert property (@(posedge clk)
    !pixel_valid |-> !texel_stall)
    else $error("texel stall with empty output stage");

  // reset empties the pipe
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !pixel_valid && !texel_stall)
    else $error("pipe not empty after reset");

  // register writes hit word addresses while no request is moving
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |->
      !texel_valid && !pixel_valid && (paddr[1:0] == 2'b00))
    else $error("register write while requests are moving");

endmodule

bind indexed_sprite_pixel_blit_top isb_checker u_isb_checker (
  .clk         (clk),
  .rst         (rst),
  .texel_valid (texel_valid),
  .texel_stall (texel_stall),
  .pixel_valid (pixel_valid),
  .pixel_stall (pixel_stall),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .pixel_color (pixel_color),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr)
);

FILE: tb/tb_indexed_sprite_pixel_blit_top.sv
// self-checking testbench for indexed_sprite_pixel_blit_top: directed texel table, then random phases
// depends on isb_pkg and the block's rtl; predicts each pixel request in a scoreboard queue
`timescale 1ns / 100ps

module tb_indexed_sprite_pixel_blit_top;
  import isb_pkg::*;

  localparam int HOLD_CYCLES = 150;

  // one template pixel as it crosses the texel channel
  typedef struct packed {
    logic [7:0]         index;
    logic [5:0]         column;
    logic [5:0]         row;
    logic signed [10:0] origin_x;
    logic signed [10:0] origin_y;
    logic               mirror;
    logic [6:0]         reveal;
    logic [8:0]         level;
  } texel_t;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] color;
  } pixel_t;

  // a table row may carry its answer typed in; otherwise the predictor decides
  typedef struct packed {
    logic   typed;
    logic   hit;
    pixel_t pix;
  } answer_t;

  typedef struct packed {
    texel_t  tex;
    answer_t ans;
  } table_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst;
  logic texel_valid;
  logic texel_stall;
  logic [7:0] pixel_index;
  logic [5:0] source_column;
  logic [5:0] source_row;
  logic signed [10:0] origin_x;
  logic signed [10:0] origin_y;
  logic mirror;
  logic [6:0] reveal_columns;
  logic [8:0] green_level;
  logic pixel_valid;
  logic pixel_stall = 1'b0;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic [15:0] pixel_color;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // shadow copy of the register file, updated only while the block is idle
  palette_t    pal_shadow;
  logic [10:0] sw_shadow;
  logic [10:0] sh_shadow;
  logic [6:0]  sprw_shadow;

  answer_t    row_answers[$];     // one entry per texel offered, popped on accept
  pixel_t     pending_pixels[$];  // predicted pixel requests, oldest first
  table_row_t texel_table[$];
  int         err_count = 0;

  // receiver stall state
  logic     hold_req;
  logic     hold_done = 1'b0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  logic [7:0] rx_cycle = '0;

  indexed_sprite_pixel_blit_top dut (
    .clk            (clk),
    .rst            (rst),
    .texel_valid    (texel_valid),
    .texel_stall    (texel_stall),
    .pixel_index    (pixel_index),
    .source_column  (source_column),
    .source_row     (source_row),
    .origin_x       (origin_x),
    .origin_y       (origin_y),
    .mirror         (mirror),
    .reveal_columns (reveal_columns),
    .green_level    (green_level),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .pixel_color    (pixel_color),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // palette lookup, column mirroring, reveal and screen clipping, q1.8 spawn tint
  function automatic logic blit_pixel(input texel_t t, output pixel_t p);
    logic [15:0] color;
    int dcol, lvl, r, g, b, sw, sh, dx, dy;
    p = '0;
    if (t.index == TRANSPARENT_INDEX) return 1'b0;
    if (t.index == EYES_INDEX) color = WHITE_565;
    else if (t.index >= FIRST_PAL_INDEX && t.index <= LAST_PAL_INDEX)
      color = pal_shadow[t.index - FIRST_PAL_INDEX];
    else return 1'b0;
    // column must lie inside the template
    if (t.column >= sprw_shadow || t.column >= MAX_SPRITE_SIDE) return 1'b0;
    if (t.row >= MAX_SPRITE_SIDE) return 1'b0;
    dcol = t.mirror ? int'(sprw_shadow) - 1 - int'(t.column) : int'(t.column);
    if (dcol >= int'(t.reveal)) return 1'b0;
    // tint level saturates at full
    lvl = (t.level > FULL_LEVEL) ? int'(FULL_LEVEL) : int'(t.level);
    if (lvl != 0) begin
      r = int'(color[15:11]) << 3;
      g = int'(color[10:5]) << 2;
      b = int'(color[4:0]) << 3;
      r = (r * (int'(FULL_LEVEL) - lvl)) >> 8;
      b = (b * (int'(FULL_LEVEL) - lvl)) >> 8;
      g = g + (((255 - g) * lvl) >> 9);
      color = {r[7:3], g[7:2], b[7:3]};
    end
    // screen sizes beyond the output range act as the range limit
    sw = (sw_shadow > COORD_LIMIT) ? int'(COORD_LIMIT) : int'(sw_shadow);
    sh = (sh_shadow > COORD_LIMIT) ? int'(COORD_LIMIT) : int'(sh_shadow);
    dx = int'($signed(t.origin_x)) + dcol;
    dy = int'($signed(t.origin_y)) + int'(t.row);
    if (dx < 0 || dx >= sw || dy < 0 || dy >= sh) return 1'b0;
    p.x = dx[9:0];
    p.y = dy[9:0];
    p.color = color;
    return 1'b1;
  endfunction

  // scoreboard: predict on texel accept, compare on pixel accept
  always @(posedge clk) begin : watch
    texel_t  seen;
    pixel_t  got;
    pixel_t  want;
    answer_t ans;
    if (!rst) begin
      if (texel_valid && !texel_stall) begin
        seen.index    = pixel_index;
        seen.column   = source_column;
        seen.row      = source_row;
        seen.origin_x = origin_x;
        seen.origin_y = origin_y;
        seen.mirror   = mirror;
        seen.reveal   = reveal_columns;
        seen.level    = green_level;
        ans = row_answers.pop_front();
        if (ans.typed) begin
          if (ans.hit) pending_pixels.push_back(ans.pix);
        end else if (blit_pixel(seen, want)) begin
          pending_pixels.push_back(want);
        end
      end
      if (pixel_valid && !pixel_stall) begin
        got = '{x: pixel_x, y: pixel_y, color: pixel_color};
        if (pending_pixels.size() == 0) begin
          err_count++;
          $display("%0t unexpected pixel request x=%0d y=%0d color=%h", $time,
                   pixel_x, pixel_y, pixel_color);
        end else begin
          want = pending_pixels.pop_front();
          if (got.x !== want.x) begin
            err_count++;
            $display("%0t pixel_x expected %0d got %0d", $time, want.x, got.x);
          end
          if (got.y !== want.y) begin
            err_count++;
            $display("%0t pixel_y expected %0d got %0d", $time, want.y, got.y);
          end
          if (got.color !== want.color) begin
            err_count++;
            $display("%0t pixel_color expected %h got %h", $time, want.color, got.color);
          end
        end
      end
    end
  end

  // receiver: its own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pixel_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      // long back-pressure so the stages fill and texel_stall rises
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      pixel_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(20, 200);
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:    pixel_stall <= 1'b0;
        RX_LIGHT:   pixel_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:   pixel_stall <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: pixel_stall <= (rx_cycle[2:0] == 3'd2) || (rx_cycle[2:0] == 3'd3);
        default:    pixel_stall <= 1'b0;
      endcase
    end
  end

  task automatic add_row(input logic [7:0] idx, input logic [5:0] col, input logic [5:0] rw,
                         input int ox, input int oy, input logic mir, input logic [6:0] rev,
                         input logic [8:0] lvl, input logic typed, input logic hit,
                         input logic [9:0] x, input logic [9:0] y, input logic [15:0] color);
    table_row_t tr;
    tr.tex = '{index: idx, column: col, row: rw, origin_x: 11'(ox), origin_y: 11'(oy),
               mirror: mir, reveal: rev, level: lvl};
    tr.ans = '{typed: typed, hit: hit, pix: '{x: x, y: y, color: color}};
    texel_table.push_back(tr);
  endtask

  // offer one texel, optionally after an idle gap; returns at its accept edge
  task automatic send_texel(input texel_t t, input answer_t a, input int gap);
    if (gap > 0) begin
      texel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_answers.push_back(a);
    pixel_index    <= t.index;
    source_column  <= t.column;
    source_row     <= t.row;
    origin_x       <= t.origin_x;
    origin_y       <= t.origin_y;
    mirror         <= t.mirror;
    reveal_columns <= t.reveal;
    green_level    <= t.level;
    texel_valid    <= 1'b1;
    do @(posedge clk); while (texel_stall);
  endtask

  // stop offering, wait out every expected pixel, then let the stages drain bubbles
  task automatic finish_phase();
    texel_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write every register over apb: setup cycle, then access until pready
  task automatic program_block(input palette_t pal, input logic [10:0] sw,
                               input logic [10:0] sh, input logic [6:0] spw);
    logic [31:0] vals [8];
    for (int i = 0; i < PAL_COUNT; i++) vals[REG_PALETTE_ONE + i] = {16'h0, pal[i]};
    vals[REG_SCREEN_WIDTH]  = {21'h0, sw};
    vals[REG_SCREEN_HEIGHT] = {21'h0, sh};
    vals[REG_SPRITE_WIDTH]  = {25'h0, spw};
    for (int r = REG_PALETTE_ONE; r <= REG_SPRITE_WIDTH; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {3'(r), 2'b00};
      pwdata  <= vals[r];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
    pal_shadow  = pal;
    sw_shadow   = sw;
    sh_shadow   = sh;
    sprw_shadow = spw;
  endtask

  // random texels shaped to land mostly on screen and inside the template
  task automatic run_phase(input int count, input logic gaps, input int hold_at);
    texel_t  t;
    answer_t none;
    int spw, swe, she, dc, tx, ty, pick, burst_left, gap;
    none = '0;
    burst_left = 0;
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_req <= 1'b1;
      spw = int'(sprw_shadow);
      swe = (sw_shadow > COORD_LIMIT) ? int'(COORD_LIMIT) : int'(sw_shadow);
      she = (sh_shadow > COORD_LIMIT) ? int'(COORD_LIMIT) : int'(sh_shadow);
      pick = $urandom_range(0, 99);
      if (pick < 60)      t.index = 8'($urandom_range(FIRST_PAL_INDEX, LAST_PAL_INDEX));
      else if (pick < 75) t.index = EYES_INDEX;
      else if (pick < 85) t.index = TRANSPARENT_INDEX;
      else                t.index = 8'($urandom_range(0, 255));
      t.mirror = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) != 0 && spw > 0)
        t.column = 6'($urandom_range(0, ((spw > 64) ? 64 : spw) - 1));
      else
        t.column = 6'($urandom_range(0, 63));
      t.row = 6'($urandom_range(0, 63));
      // aim the destination around the visible area, edges included
      dc = t.mirror ? spw - 1 - int'(t.column) : int'(t.column);
      tx = int'($urandom_range(0, swe + 7)) - 4;
      ty = int'($urandom_range(0, she + 7)) - 4;
      if ($urandom_range(0, 6) == 0) begin
        t.origin_x = 11'($urandom);
        t.origin_y = 11'($urandom);
      end else begin
        t.origin_x = 11'(tx - dc);
        t.origin_y = 11'(ty - int'(t.row));
      end
      pick = $urandom_range(0, 9);
      if (pick < 4)      t.reveal = 7'((spw > 127) ? 127 : spw);
      else if (pick < 8) t.reveal = 7'($urandom_range(0, 64));
      else               t.reveal = 7'($urandom_range(0, 127));
      pick = $urandom_range(0, 9);
      if (pick < 4)      t.level = 9'd0;
      else if (pick < 8) t.level = 9'($urandom_range(1, 256));
      else if (pick < 9) t.level = FULL_LEVEL;
      else               t.level = 9'($urandom_range(257, 511));
      // sender bursts with idle gaps between them
      gap = 0;
      if (gaps) begin
        if (burst_left == 0) begin
          gap = $urandom_range(1, 6);
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
      end
      send_texel(t, none, gap);
    end
  endtask

  initial begin
    palette_t pal;
    rst            <= 1'b1;
    texel_valid    <= 1'b0;
    pixel_index    <= '0;
    source_column  <= '0;
    source_row     <= '0;
    origin_x       <= '0;
    origin_y       <= '0;
    mirror         <= 1'b0;
    reveal_columns <= '0;
    green_level    <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    hold_req       <= 1'b0;
    pal_shadow  = '0;
    sw_shadow   = SCREEN_WIDTH_RST;
    sh_shadow   = SCREEN_HEIGHT_RST;
    sprw_shadow = SPRITE_WIDTH_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows run on the reset registers: 320x240 screen, 16 wide sprite, black palette
    //      index              col    row    ox     oy    mir   rev     lvl     ty    hit   x y c
    add_row(TRANSPARENT_INDEX, 6'd0,  6'd0,  10,    10,   1'b0, 7'd64,  9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd0,  6'd0,  0,     0,    1'b0, 7'd16,  9'd0,   1'b1, 1'b1, 0, 0, WHITE_565);
    add_row(8'd255,            6'd0,  6'd0,  0,     0,    1'b0, 7'd16,  9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(8'd7,              6'd0,  6'd0,  0,     0,    1'b0, 7'd16,  9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(FIRST_PAL_INDEX,   6'd15, 6'd63, 304,   0,    1'b0, 7'd16,  9'd0,   1'b1, 1'b1, 319, 63, 0);
    // column outside the template
    add_row(EYES_INDEX,        6'd16, 6'd0,  0,     0,    1'b0, 7'd64,  9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd63, 6'd0,  0,     0,    1'b0, 7'd64,  9'd0,   1'b1, 1'b0, 0, 0, 0);
    // mirrored columns
    add_row(EYES_INDEX,        6'd0,  6'd0,  0,     0,    1'b1, 7'd16,  9'd0,   1'b1, 1'b1, 15, 0, WHITE_565);
    add_row(EYES_INDEX,        6'd15, 6'd0,  0,     0,    1'b1, 7'd1,   9'd0,   1'b1, 1'b1, 0, 0, WHITE_565);
    // reveal limit
    add_row(EYES_INDEX,        6'd0,  6'd0,  0,     0,    1'b0, 7'd0,   9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd5,  6'd0,  0,     0,    1'b0, 7'd5,   9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd4,  6'd0,  10,    20,   1'b0, 7'd5,   9'd0,   1'b1, 1'b1, 14, 20, WHITE_565);
    add_row(EYES_INDEX,        6'd0,  6'd0,  7,     9,    1'b0, 7'd127, 9'd0,   1'b1, 1'b1, 7, 9, WHITE_565);
    // screen edges and origin extremes
    add_row(EYES_INDEX,        6'd0,  6'd0,  -1024, 0,    1'b0, 7'd16,  9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd1,  6'd0,  -1,    0,    1'b0, 7'd16,  9'd0,   1'b1, 1'b1, 0, 0, WHITE_565);
    add_row(EYES_INDEX,        6'd0,  6'd0,  1023,  0,    1'b0, 7'd16,  9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd0,  6'd0,  319,   239,  1'b0, 7'd16,  9'd0,   1'b1, 1'b1, 319, 239, WHITE_565);
    add_row(EYES_INDEX,        6'd0,  6'd1,  0,     239,  1'b0, 7'd16,  9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd0,  6'd0,  0,     -1024, 1'b0, 7'd16, 9'd0,   1'b1, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd0,  6'd63, 0,     -63,  1'b0, 7'd16,  9'd0,   1'b1, 1'b1, 0, 0, WHITE_565);
    // full tint turns white into pure green; levels above full saturate
    add_row(EYES_INDEX,        6'd0,  6'd0,  5,     5,    1'b0, 7'd16,  FULL_LEVEL, 1'b1, 1'b1, 5, 5, 16'h07E0);
    add_row(EYES_INDEX,        6'd0,  6'd0,  5,     5,    1'b0, 7'd16,  9'd511, 1'b1, 1'b1, 5, 5, 16'h07E0);
    // partial tints and the palette indexes go through the predictor
    add_row(EYES_INDEX,        6'd2,  6'd3,  40,    50,   1'b0, 7'd16,  9'd1,   1'b0, 1'b0, 0, 0, 0);
    add_row(EYES_INDEX,        6'd3,  6'd4,  40,    50,   1'b1, 7'd16,  9'd128, 1'b0, 1'b0, 0, 0, 0);
    add_row(8'd2,              6'd6,  6'd42, 100,   100,  1'b0, 7'd64,  9'd200, 1'b0, 1'b0, 0, 0, 0);
    add_row(8'd3,              6'd7,  6'd21, 200,   10,   1'b1, 7'd64,  9'd0,   1'b0, 1'b0, 0, 0, 0);
    add_row(8'd4,              6'd8,  6'd0,  0,     0,    1'b0, 7'd64,  9'd255, 1'b0, 1'b0, 0, 0, 0);
    add_row(LAST_PAL_INDEX,    6'd9,  6'd10, 300,   220,  1'b1, 7'd64,  9'd64,  1'b0, 1'b0, 0, 0, 0);
    foreach (texel_table[i])
      send_texel(texel_table[i].tex, texel_table[i].ans,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    finish_phase();

    // largest legal screen and sprite; the long receiver hold-off lands here
    for (int i = 0; i < PAL_COUNT; i++) pal[i] = 16'($urandom);
    program_block(pal, 11'd1024, 11'd1024, 7'd64);
    run_phase(120, 1'b1, 20);
    finish_phase();

    // smallest screen and sprite, palette at the colour extremes
    pal = {16'h001F, 16'h07E0, 16'hF800, 16'hFFFF, 16'h0000};
    program_block(pal, 11'd1, 11'd1, 7'd1);
    run_phase(80, 1'b1, -1);
    finish_phase();

    // screen beyond the output range acts as 1024; back-to-back texels with no gaps
    for (int i = 0; i < PAL_COUNT; i++) pal[i] = 16'($urandom);
    program_block(pal, 11'd2047, 11'd2047, 7'd127);
    run_phase(100, 1'b0, -1);
    finish_phase();

    // zero width draws nothing
    for (int i = 0; i < PAL_COUNT; i++) pal[i] = 16'($urandom);
    program_block(pal, 11'd0, 11'd600, 7'd40);
    run_phase(30, 1'b1, -1);
    finish_phase();

    // random mid-range setting
    for (int i = 0; i < PAL_COUNT; i++) pal[i] = 16'($urandom);
    program_block(pal, 11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
                  7'($urandom_range(1, 64)));
    run_phase(170, 1'b1, -1);
    finish_phase();

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
